[rtl/fdia_pkg.sv]
package fdia_pkg;

   localparam int Capacity     = 128;
   localparam int FirstFree    = 4;
   localparam int PendingDepth = 128;

   localparam int CapW  = $clog2(Capacity);
   localparam int CntW  = $clog2(Capacity + 1);
   localparam int PendW = $clog2(PendingDepth);
   localparam int PcntW = $clog2(PendingDepth + 1);
   localparam int QDepth = 2;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_FLUSH = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_QFULL     = 2'd2,
      ST_NULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [6:0]  slot_index;
      logic        null_handle;
      logic [63:0] fence_value;
   } req_type;

   typedef struct packed {
      logic [6:0] granted_index;
      logic [1:0] status;
      logic [7:0] released_count;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      opcode_type  op;
      logic [6:0]  slot;
      logic [63:0] fence;
      logic        ignore;
   } cmd_type;

endpackage

[rtl/fence_deferred_index_allocator_unit.sv]
// Slot index allocator with fence-deferred release.
// req_ channel: one transaction per command (allocate, free, flush, no-op), valid/ready.
// rsp_ channel: exactly one result transaction per command, in order.
// A two-entry command queue decouples acceptance from execution, so commands
// are taken while a result waits on rsp_ready.
// Allocate from the never-used range, free and no-op pass the queue and
// execute in S_IDLE; allocate from the free stack adds a stack read (S_POP).
// Flush handles each of N pending entries with a read (S_FREAD) and a
// write-back (S_FSTEP) on the single-ported pending store, then S_RESP.
// The back end runs one command at a time; the next starts once
// the previous result has been taken.
// Reset (synchronous, active high) empties the free stack and pending queue
// and restarts never-used allocation at FirstFree; stores need no clearing.
// When rsp_ready is low the result holds, the back end stalls and req_ready
// drops once the command queue fills.
module fence_deferred_index_allocator_unit import fdia_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    cmd_valid, cmd_ready;
   cmd_type cmd_data;

   fdia_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .cmd_valid, .cmd_ready, .cmd_data
   );

   fdia_back u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

endmodule

[rtl/fdia_front.sv]
module fdia_front import fdia_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    cmd_valid,
   input  logic    cmd_ready,
   output cmd_type cmd_data
);

   localparam int QW = $clog2(QDepth);

   cmd_type           q_ff [QDepth];
   logic [QW-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [QW:0]       cnt_ff, cnt_in;
   cmd_type           cmd_in;
   logic              push, pop;

   always_comb begin
      cmd_in.op     = opcode_type'(req_data.opcode);
      cmd_in.slot   = req_data.slot_index;
      cmd_in.fence  = req_data.fence_value;
      cmd_in.ignore = (req_data.opcode == OP_FREE) && req_data.null_handle;
   end

   assign req_ready = (cnt_ff != (QW+1)'(QDepth));
   assign push      = req_valid && req_ready;
   assign cmd_valid = (cnt_ff != '0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd_data  = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? QW'(wp_ff + 1'b1) : wp_ff;
      rp_in  = pop ? QW'(rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (QW+1)'(push) - (QW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wp_ff] <= cmd_in;
   end

endmodule

[rtl/fdia_back.sv]
module fdia_back import fdia_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE, S_POP, S_FREAD, S_FSTEP, S_RESP
   } state_type;

   state_type          state_ff;
   logic [6:0]         fstack [Capacity];
   logic [6:0]         pslot  [PendingDepth];
   logic [63:0]        pfence [PendingDepth];
   logic [CntW-1:0]    fdepth_ff;
   logic [CntW-1:0]    next_ff;
   logic [PcntW-1:0]   pdepth_ff;
   logic [PcntW-1:0]   rd_ff, wr_ff;
   logic [63:0]        fence_ff;
   logic [7:0]         rel_ff;
   logic [6:0]         fs_rd_ff, ps_rd_ff;
   logic [63:0]        pf_rd_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   assign cmd_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fdepth_ff    <= '0;
         next_ff      <= CntW'(FirstFree);
         pdepth_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         rd_ff        <= '0;
         wr_ff        <= '0;
         rel_ff       <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid && cmd_ready) begin
                  unique case (cmd_data.op)
                     OP_ALLOC: begin
                        if (fdepth_ff != '0) begin
                           rsp_ff    <= '0;
                           fs_rd_ff  <= fstack[CapW'(fdepth_ff - 1'b1)];
                           fdepth_ff <= fdepth_ff - 1'b1;
                           state_ff  <= S_POP;
                        end else if (next_ff < CntW'(Capacity)) begin
                           rsp_ff       <= {7'(next_ff), ST_OK, 8'd0};
                           next_ff      <= next_ff + 1'b1;
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           rsp_ff       <= {7'd0, ST_EXHAUSTED, 8'd0};
                           rsp_valid_ff <= 1'b1;
                        end
                     end
                     OP_FREE: begin
                        if (cmd_data.ignore) begin
                           rsp_ff <= {7'd0, ST_NULL, 8'd0};
                        end else if (pdepth_ff == PcntW'(PendingDepth)) begin
                           rsp_ff <= {7'd0, ST_QFULL, 8'd0};
                        end else begin
                           rsp_ff <= {7'd0, ST_OK, 8'd0};
                           pslot[PendW'(pdepth_ff)]  <= cmd_data.slot;
                           pfence[PendW'(pdepth_ff)] <= cmd_data.fence;
                           pdepth_ff <= pdepth_ff + 1'b1;
                        end
                        rsp_valid_ff <= 1'b1;
                     end
                     OP_FLUSH: begin
                        rsp_ff   <= '0;
                        fence_ff <= cmd_data.fence;
                        rd_ff    <= '0;
                        wr_ff    <= '0;
                        rel_ff   <= '0;
                        state_ff <= S_FREAD;
                     end
                     default: begin
                        rsp_ff       <= '0;
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            S_POP: begin
               rsp_ff.granted_index <= fs_rd_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_FREAD: begin
               if (rd_ff == pdepth_ff) begin
                  pdepth_ff <= wr_ff;
                  rsp_ff.released_count <= rel_ff;
                  state_ff <= S_RESP;
               end else begin
                  ps_rd_ff <= pslot[PendW'(rd_ff)];
                  pf_rd_ff <= pfence[PendW'(rd_ff)];
                  state_ff <= S_FSTEP;
               end
            end
            S_FSTEP: begin
               if (pf_rd_ff <= fence_ff && fdepth_ff < CntW'(Capacity)) begin
                  fstack[CapW'(fdepth_ff)] <= ps_rd_ff;
                  fdepth_ff <= fdepth_ff + 1'b1;
                  if (rel_ff != 8'hFF) rel_ff <= rel_ff + 1'b1;
               end else begin
                  pslot[PendW'(wr_ff)]  <= ps_rd_ff;
                  pfence[PendW'(wr_ff)] <= pf_rd_ff;
                  wr_ff <= wr_ff + 1'b1;
               end
               rd_ff    <= rd_ff + 1'b1;
               state_ff <= S_FREAD;
            end
            S_RESP: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[rtl/fdia_checker.sv]
module fdia_checker import fdia_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped under stall");

   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.granted_index != '0 |-> rsp_data.status == ST_OK
                                                && rsp_data.released_count == '0)
      else $error("grant with bad status");

   a_rel_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.released_count != '0 |-> rsp_data.status == ST_OK)
      else $error("release with bad status");

   a_no_early: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result straight after reset");

endmodule

bind fence_deferred_index_allocator_unit fdia_checker u_chk (.*);

[tb/tb_fence_deferred_index_allocator_unit.sv]
module tb_fence_deferred_index_allocator_unit;
   import fdia_pkg::*;

   // Scoreboard: shadow of the allocator state and queue of awaited results
   class alloc_scoreboard;
      logic [6:0]  free_stack [Capacity];
      int          free_fill;
      int          next_fresh;
      logic [6:0]  pend_slot [PendingDepth];
      logic [63:0] pend_fence [PendingDepth];
      int          pend_fill;
      rsp_type     awaited [$];
      int          errors;

      function void clear();
         free_fill  = 0;
         next_fresh = FirstFree;
         pend_fill  = 0;
         awaited.delete();
         errors     = 0;
      endfunction

      function void note_command(req_type r);
         rsp_type res;
         int      wr;
         int      rel;
         res = '0;
         rel = 0;
         case (opcode_type'(r.opcode))
            OP_ALLOC: begin
               if (free_fill > 0) begin
                  free_fill--;
                  res.granted_index = free_stack[free_fill];
               end else if (next_fresh < Capacity) begin
                  res.granted_index = next_fresh[6:0];
                  next_fresh++;
               end else begin
                  res.status = ST_EXHAUSTED;
               end
            end
            OP_FREE: begin
               if (r.null_handle) begin
                  res.status = ST_NULL;
               end else if (pend_fill >= PendingDepth) begin
                  res.status = ST_QFULL;
               end else begin
                  pend_slot[pend_fill]  = r.slot_index;
                  pend_fence[pend_fill] = r.fence_value;
                  pend_fill++;
               end
            end
            OP_FLUSH: begin
               wr = 0;
               for (int rd = 0; rd < pend_fill; rd++) begin
                  if (pend_fence[rd] <= r.fence_value && free_fill < Capacity) begin
                     free_stack[free_fill] = pend_slot[rd];
                     free_fill++;
                     if (rel < 255) rel++;
                  end else begin
                     pend_slot[wr]  = pend_slot[rd];
                     pend_fence[wr] = pend_fence[rd];
                     wr++;
                  end
               end
               pend_fill = wr;
               res.released_count = rel[7:0];
            end
            default: ;
         endcase
         awaited = {awaited, res};
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (got.granted_index !== want.granted_index) begin
            $display("%0t: granted_index expected %0d actual %0d", $time,
                     want.granted_index, got.granted_index);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.released_count !== want.released_count) begin
            $display("%0t: released_count expected %0d actual %0d", $time,
                     want.released_count, got.released_count);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;

   alloc_scoreboard board;
   bit      hold_off = 0;
   bit      sink_gaps = 1;
   logic [63:0] fence_now = 0;

   fence_deferred_index_allocator_unit DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function int short_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // one transaction on req_, then an optional gap
   task automatic send_cmd(opcode_type op, logic [6:0] slot, logic nul, logic [63:0] fence,
                           bit gaps = 1'b1);
      int g;
      req_data.opcode      = op;
      req_data.slot_index  = slot;
      req_data.null_handle = nul;
      req_data.fence_value = fence;
      req_valid = 1;
      do @(posedge clock); while (!req_ready);
      board.note_command(req_data);
      @(negedge clock);
      req_valid = 0;
      g = gaps ? short_gap() : 0;
      repeat (g) @(negedge clock);
   endtask

   task automatic drain();
      while (board.awaited.size() != 0) @(negedge clock);
   endtask

   task automatic random_cmd();
      int          pick;
      logic [63:0] f;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         send_cmd(OP_ALLOC, 7'($urandom), 1'($urandom), {$urandom, $urandom});
      end else if (pick < 80) begin
         fence_now = fence_now + $urandom_range(0, 3);
         f = ($urandom_range(0, 30) == 0) ? {$urandom, $urandom} : fence_now;
         send_cmd(OP_FREE, 7'($urandom), $urandom_range(0, 15) == 0, f);
      end else if (pick < 97) begin
         f = fence_now - $urandom_range(0, 6);
         if ($urandom_range(0, 15) == 0) f = {$urandom, $urandom};
         send_cmd(OP_FLUSH, 7'($urandom), 1'($urandom), f);
      end else begin
         send_cmd(OP_NONE, 7'($urandom), 1'($urandom), {$urandom, $urandom});
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
   end

   always @(negedge clock) begin
      if (hold_off) rsp_ready <= 0;
      else if (!sink_gaps) rsp_ready <= 1;
      else if ($urandom_range(0, 49) == 0) rsp_ready <= 0;
      else if (!rsp_ready) rsp_ready <= $urandom_range(0, 3) == 0;
      else rsp_ready <= $urandom_range(0, 4) != 0;
   end

   initial begin
      #30000000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      board = new();
      board.clear();
      repeat (4) @(negedge clock);
      reset = 0;

      // directed: extremes, null free, unused opcode, wide fences
      sink_gaps = 0;
      send_cmd(OP_ALLOC, 7'h7f, 1'b1, '1);
      send_cmd(OP_NONE, 7'h7f, 1'b1, '1);
      send_cmd(OP_FREE, 7'h7f, 1'b1, '1);
      send_cmd(OP_FREE, 7'h7f, 1'b0, '1);
      send_cmd(OP_FREE, 7'h00, 1'b0, '0);
      send_cmd(OP_FREE, 7'h55, 1'b0, 64'h0000_0001_0000_0000);
      send_cmd(OP_FLUSH, 7'h2a, 1'b1, 64'h0000_0000_FFFF_FFFF);
      send_cmd(OP_ALLOC, '0, 1'b0, '0);
      send_cmd(OP_FLUSH, '0, 1'b0, '1);
      send_cmd(OP_ALLOC, '0, 1'b0, '0);
      send_cmd(OP_ALLOC, '0, 1'b0, '0);
      send_cmd(OP_ALLOC, '0, 1'b0, '0);

      // exhaust the fresh range, then fill the pending queue past full
      repeat (126) send_cmd(OP_ALLOC, '0, 1'b0, '0, 1'b0);
      for (int i = 0; i < 130; i++) send_cmd(OP_FREE, i[6:0], 1'b0, 64'(i), 1'b0);
      // free stack fills at capacity; stragglers stay queued
      send_cmd(OP_FLUSH, '0, 1'b0, '1);
      for (int i = 0; i < 6; i++) send_cmd(OP_FREE, i[6:0], 1'b0, '0, 1'b0);
      send_cmd(OP_FLUSH, '0, 1'b0, '1);
      repeat (130) send_cmd(OP_ALLOC, '0, 1'b0, '0, 1'b0);
      send_cmd(OP_FLUSH, '0, 1'b0, '1);
      repeat (6) send_cmd(OP_ALLOC, '0, 1'b0, '0, 1'b0);
      sink_gaps = 1;
      drain();

      // long receiver stall while the sender keeps offering
      fork
         begin
            hold_off = 1;
            repeat (300) @(negedge clock);
            hold_off = 0;
         end
         repeat (20) random_cmd();
      join

      for (int n = 0; n < 1200; n++) begin
         if (n % 400 == 399) begin
            // burst of allocations to reach exhaustion again mid-run
            repeat (40) send_cmd(OP_ALLOC, 7'($urandom), 1'($urandom), '0);
         end
         random_cmd();
      end

      drain();
      repeat (50) @(posedge clock);
      if (board.errors == 0 && board.awaited.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
